// File: rtl/core/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// Line follower PID drive package
// Widths, constants and register codes shared by the line follower PID drive.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int POS_W     = 13;
  localparam int ERR_W     = 13;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int SUM_W     = 24;
  localparam int GAIN_W    = 24;
  localparam int SPEED_W   = 8;
  localparam int LOWER_W   = 9;
  localparam int CORR_W    = 16;
  localparam int MAG_W     = 8;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int Q_SHIFT   = 20;

  localparam int PROP_W  = GAIN_W + 1 + ERR_W;
  localparam int DERIV_W = GAIN_W + 1 + DIFF_W;
  localparam int INTEG_W = GAIN_W + 1 + SUM_W;
  localparam int ACC_W   = INTEG_W + 1;
  localparam int CMD_W   = CORR_W + 2;

  localparam int CENTER_POSITION  = 3000;
  localparam int GLITCH_ERROR     = 3000;
  localparam int GLITCH_NEIGHBOUR = 1100;
  localparam int STRAIGHT_BAND    = 200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN      = 3'd0,
    CFG_INTEG_GAIN     = 3'd1,
    CFG_DERIV_GAIN     = 3'd2,
    CFG_BASE_SPEED     = 3'd3,
    CFG_STRAIGHT_SPEED = 3'd4,
    CFG_UPPER_LIMIT    = 3'd5,
    CFG_LOWER_LIMIT    = 3'd6
  } cfg_idx_e;

  localparam logic [GAIN_W-1:0]         PROP_GAIN_RST      = 24'd73820;
  localparam logic [GAIN_W-1:0]         INTEG_GAIN_RST     = 24'd745;
  localparam logic [GAIN_W-1:0]         DERIV_GAIN_RST     = 24'd492831;
  localparam logic [SPEED_W-1:0]        BASE_SPEED_RST     = 8'd70;
  localparam logic [SPEED_W-1:0]        STRAIGHT_SPEED_RST = 8'd255;
  localparam logic [SPEED_W-1:0]        UPPER_LIMIT_RST    = 8'd140;
  localparam logic signed [LOWER_W-1:0] LOWER_LIMIT_RST    = -9'sd170;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic signed [ACC_W-1:0] Q_ROUND  = ACC_W'((64'd1 << Q_SHIFT) - 64'd1);
  localparam logic signed [ACC_W-1:0] CORR_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] CORR_MIN = -ACC_W'(32768);

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             reverse;
  } motor_t;

endpackage

// File: rtl/core/lfpd_pos_if.sv
// ----------------------------------------------------------------------------
// Line position channel
// Carries one line-position sample per transaction with valid and ready.
// ----------------------------------------------------------------------------
interface lfpd_pos_if;
  logic                         valid;
  logic                         ready;
  logic [lfpd_pkg::POS_W-1:0]   line_position;

  modport source (output valid, output line_position, input ready);
  modport sink (input valid, input line_position, output ready);
endinterface

// File: rtl/core/lfpd_drv_if.sv
// ----------------------------------------------------------------------------
// Motor drive channel
// Carries both motor commands and the PID correction per transaction.
// ----------------------------------------------------------------------------
interface lfpd_drv_if;
  logic                               valid;
  logic                               ready;
  logic [lfpd_pkg::MAG_W-1:0]         right_magnitude;
  logic                               right_reverse;
  logic [lfpd_pkg::MAG_W-1:0]         left_magnitude;
  logic                               left_reverse;
  logic signed [lfpd_pkg::CORR_W-1:0] correction;

  modport source (output valid, output right_magnitude, output right_reverse,
                  output left_magnitude, output left_reverse, output correction,
                  input ready);
  modport sink (input valid, input right_magnitude, input right_reverse,
                input left_magnitude, input left_reverse, input correction,
                output ready);
endinterface

// File: rtl/core/line_follow_pid_drive.sv
// ----------------------------------------------------------------------------
// Line follower PID drive
// Turns line-position samples into differential motor commands by PID control.
// ----------------------------------------------------------------------------
// Usage: line-position samples arrive on pos_i and motor commands leave on
// drv_o, both as valid/ready channels with one transaction per item. Each
// sample yields exactly one result carrying both motor magnitudes, their
// reverse flags and the saturated PID correction.
// The error history and the integral are updated as a sample is accepted;
// three further stages form the gain products, the scaled correction and the
// clamped motor commands, which are registered onto drv_o. A new sample can be
// accepted in every cycle while the output is not stalled, so the throughput
// is one transaction per cycle whenever the receiver keeps ready high.
// When the receiver holds ready low with a result pending, every stage
// freezes and pos_i.ready drops until that result is taken.
// The user writes gains, speeds and limits through the cfg port only while no
// sample is in flight; the block does not enforce it. Reset restores default
// gains and limits, clears error history and integral, empties the pipeline.
// ----------------------------------------------------------------------------
module line_follow_pid_drive (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lfpd_pos_if.sink                         pos_i,
  lfpd_drv_if.source                       drv_o,
  input  logic                             cfg_we_i,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lfpd_pkg::CFG_W-1:0]       cfg_data_i
);
  import lfpd_pkg::*;

  logic [GAIN_W-1:0]         prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [SPEED_W-1:0]        base_speed_q, straight_speed_q, upper_limit_q;
  logic signed [LOWER_W-1:0] lower_limit_q;

  logic signed [ERR_W-1:0] err_now_q, err_before_q;
  logic signed [SUM_W-1:0] err_sum_q;

  logic                     s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic signed [ERR_W-1:0]  s1_err_q;
  logic signed [DIFF_W-1:0] s1_diff_q;
  logic signed [SUM_W-1:0]  s1_sum_q;
  logic                     s1_small_q, s2_small_q, s3_small_q;
  logic signed [PROP_W-1:0]  s2_prop_q;
  logic signed [DERIV_W-1:0] s2_deriv_q;
  logic signed [INTEG_W-1:0] s2_integ_q;
  logic signed [CORR_W-1:0]  s3_corr_q;
  motor_t                    right_q, left_q;
  logic signed [CORR_W-1:0]  corr_out_q;

  logic stall, in_fire;

  logic signed [ERR_W+1:0] pos_off;
  logic signed [ERR_W-1:0] err_raw, err_d;
  logic                    glitch, small_err;
  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W-1:0] err_sum_d;
  logic signed [DIFF_W-1:0] diff_d;

  logic signed [PROP_W-1:0]  prop_prod;
  logic signed [DERIV_W-1:0] deriv_prod;
  logic signed [INTEG_W-1:0] integ_prod;

  logic signed [ACC_W-1:0]  acc, acc_biased, acc_quot;
  logic signed [CORR_W-1:0] corr_d;

  logic signed [CMD_W-1:0] speed_ext, corr_ext, lo_ext, hi_ext;
  motor_t                  right_d, left_d;

  assign stall       = out_valid_q && !drv_o.ready;
  assign pos_i.ready = !stall;
  assign in_fire     = pos_i.valid && !stall;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q      <= PROP_GAIN_RST;
      integ_gain_q     <= INTEG_GAIN_RST;
      deriv_gain_q     <= DERIV_GAIN_RST;
      base_speed_q     <= BASE_SPEED_RST;
      straight_speed_q <= STRAIGHT_SPEED_RST;
      upper_limit_q    <= UPPER_LIMIT_RST;
      lower_limit_q    <= LOWER_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PROP_GAIN:      prop_gain_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEG_GAIN:     integ_gain_q     <= cfg_data_i[GAIN_W-1:0];
        CFG_DERIV_GAIN:     deriv_gain_q     <= cfg_data_i[GAIN_W-1:0];
        CFG_BASE_SPEED:     base_speed_q     <= cfg_data_i[SPEED_W-1:0];
        CFG_STRAIGHT_SPEED: straight_speed_q <= cfg_data_i[SPEED_W-1:0];
        CFG_UPPER_LIMIT:    upper_limit_q    <= cfg_data_i[SPEED_W-1:0];
        CFG_LOWER_LIMIT:    lower_limit_q    <= $signed(cfg_data_i[LOWER_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Error, glitch suppression and integral update for the accepted sample.
  always_comb begin
    pos_off = $signed({2'b00, pos_i.line_position}) - (ERR_W+2)'(CENTER_POSITION);
    if (pos_off > (ERR_W+2)'(4095)) begin
      err_raw = ERR_W'(4095);
    end else if (pos_off < -(ERR_W+2)'(4096)) begin
      err_raw = -ERR_W'(4096);
    end else begin
      err_raw = pos_off[ERR_W-1:0];
    end

    glitch = (err_raw == ERR_W'(GLITCH_ERROR) || err_raw == -ERR_W'(GLITCH_ERROR)) &&
             err_now_q > -ERR_W'(GLITCH_NEIGHBOUR) &&
             err_now_q < ERR_W'(GLITCH_NEIGHBOUR) &&
             err_before_q > -ERR_W'(GLITCH_NEIGHBOUR) &&
             err_before_q < ERR_W'(GLITCH_NEIGHBOUR);
    err_d = glitch ? '0 : err_raw;

    small_err = err_d >= -ERR_W'(STRAIGHT_BAND) && err_d <= ERR_W'(STRAIGHT_BAND);

    sum_ext = (SUM_W+1)'(err_sum_q) + (SUM_W+1)'(err_d);
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      err_sum_d = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      err_sum_d = sum_ext[SUM_W-1:0];
    end

    diff_d = DIFF_W'(err_d) - DIFF_W'(err_now_q);
  end

  assign prop_prod  = $signed({1'b0, prop_gain_q}) * s1_err_q;
  assign deriv_prod = $signed({1'b0, deriv_gain_q}) * s1_diff_q;
  assign integ_prod = $signed({1'b0, integ_gain_q}) * s1_sum_q;

  // Sum of products, scaled down with truncation toward zero and saturated.
  always_comb begin
    acc        = ACC_W'(s2_prop_q) + ACC_W'(s2_deriv_q) + ACC_W'(s2_integ_q);
    acc_biased = acc + (acc[ACC_W-1] ? Q_ROUND : '0);
    acc_quot   = acc_biased >>> Q_SHIFT;
    if (acc_quot > CORR_MAX) begin
      corr_d = CORR_W'(CORR_MAX);
    end else if (acc_quot < CORR_MIN) begin
      corr_d = CORR_W'(CORR_MIN);
    end else begin
      corr_d = acc_quot[CORR_W-1:0];
    end
  end

  function automatic motor_t drive(input logic signed [CMD_W-1:0] cmd,
                                   input logic signed [CMD_W-1:0] lo,
                                   input logic signed [CMD_W-1:0] hi);
    logic signed [CMD_W-1:0] raised, limited, absval;
    motor_t                  res;
    raised        = (cmd < lo) ? lo : cmd;
    limited       = (raised > hi) ? hi : raised;
    res.reverse   = limited[CMD_W-1];
    absval        = res.reverse ? -limited : limited;
    res.magnitude = (absval > CMD_W'(255)) ? '1 : absval[MAG_W-1:0];
    return res;
  endfunction

  always_comb begin
    speed_ext = $signed({{(CMD_W-SPEED_W){1'b0}},
                         (s3_small_q ? straight_speed_q : base_speed_q)});
    corr_ext  = CMD_W'(s3_corr_q);
    lo_ext    = CMD_W'(lower_limit_q);
    hi_ext    = $signed({{(CMD_W-SPEED_W){1'b0}}, upper_limit_q});
    right_d   = drive(speed_ext - corr_ext, lo_ext, hi_ext);
    left_d    = drive(speed_ext + corr_ext, lo_ext, hi_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_now_q    <= '0;
      err_before_q <= '0;
      err_sum_q    <= '0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        err_now_q    <= err_d;
        err_before_q <= err_now_q;
        err_sum_q    <= err_sum_d;
      end
      if (!stall) begin
        s1_valid_q  <= pos_i.valid;
        s2_valid_q  <= s1_valid_q;
        s3_valid_q  <= s2_valid_q;
        out_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      s1_err_q   <= err_d;
      s1_diff_q  <= diff_d;
      s1_sum_q   <= err_sum_d;
      s1_small_q <= small_err;
      s2_prop_q  <= prop_prod;
      s2_deriv_q <= deriv_prod;
      s2_integ_q <= integ_prod;
      s2_small_q <= s1_small_q;
      s3_corr_q  <= corr_d;
      s3_small_q <= s2_small_q;
      right_q    <= right_d;
      left_q     <= left_d;
      corr_out_q <= s3_corr_q;
    end
  end

  assign drv_o.valid           = out_valid_q;
  assign drv_o.right_magnitude = right_q.magnitude;
  assign drv_o.right_reverse   = right_q.reverse;
  assign drv_o.left_magnitude  = left_q.magnitude;
  assign drv_o.left_reverse    = left_q.reverse;
  assign drv_o.correction      = corr_out_q;

`ifndef SYNTHESIS
  a_err_history : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> err_before_q == $past(err_now_q))
    else $error("Previous error not shifted on a transaction");

  a_sum_hold_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && err_sum_q == SUM_MAX && err_d >= 0 |=> err_sum_q == SUM_MAX)
    else $error("Integral left positive saturation");

  a_zero_corr_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && corr_out_q == '0 |->
      right_q.magnitude == left_q.magnitude && right_q.reverse == left_q.reverse)
    else $error("Motor commands differ with zero correction");

  a_out_from_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s3_valid_q))
    else $error("Result appeared without an item in the last stage");
`endif

endmodule
